@@ hw/rtl/skvt_pkg.sv @@
// skvt_pkg: shared types and result codes of the small key-value table
// used by the top level, by the matcher and by the port checker; no dependencies

package skvt_pkg;

    // result status of one item
    typedef logic [2:0] skvt_status_t;

    localparam skvt_status_t ST_UPDATED   = 3'd0;
    localparam skvt_status_t ST_INSERTED  = 3'd1;
    localparam skvt_status_t ST_FULL      = 3'd2;
    localparam skvt_status_t ST_FOUND     = 3'd3;
    localparam skvt_status_t ST_NOT_FOUND = 3'd4;

    // command codes on the input channel
    localparam logic CMD_SET    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // fixed widths of the ports
    localparam int PORT_KEY_W   = 32;
    localparam int PORT_VALUE_W = 32;
    localparam int TOL_W        = 31;

endpackage

@@ hw/rtl/skvt_match.sv @@
// skvt_match: tolerance key comparator, |a - b| < tolerance or a == b
// keys are signed two's complement of KEY_WIDTH bits; uses skvt_pkg

module skvt_match
    import skvt_pkg::*;
#(
    parameter int KEY_WIDTH = 32
)
(
    input  logic [KEY_WIDTH-1:0] key_a,
    input  logic [KEY_WIDTH-1:0] key_b,
    input  logic [TOL_W-1:0]     tolerance,
    output logic                 match
);

    localparam int DIFF_W = KEY_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

    logic [DIFF_W-1:0] diff_ab;
    logic [DIFF_W-1:0] diff_ba;
    logic [DIFF_W-1:0] magnitude;

    // both differences in parallel, pick the non-negative one
    assign diff_ab = {key_a[KEY_WIDTH-1], key_a} - {key_b[KEY_WIDTH-1], key_b};
    assign diff_ba = {key_b[KEY_WIDTH-1], key_b} - {key_a[KEY_WIDTH-1], key_a};
    assign magnitude = diff_ab[DIFF_W-1] ? diff_ba : diff_ab;

    // equal keys always match, else compare the distance with the tolerance
    assign match = (key_a == key_b) ||
                   (CMP_W'(magnitude) < CMP_W'(tolerance));

endmodule

@@ hw/rtl/small_key_value_table.sv @@
// small_key_value_table: associative key-value store filled in order
// depends on skvt_pkg and skvt_match
//
// Input channel (in_valid/in_ready): command, key, value. A set updates the
// value of the first matching entry, else appends the pair, else reports
// full. A lookup returns the value of the first matching entry or not found.
// Keys match when equal or when their distance is below the tolerance
// register, written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle; the block does not enforce it. Output channel
// (out_valid/out_ready): status and read_value, one item per input item,
// in order. Sequencing: one item at a time. An accepted item is latched,
// then searched over the filled entries, one key memory read per cycle,
// compared on the registered read data in the next cycle; a hit ends the
// search early. The done state hands the result to the output register.
// The output register holds a finished result while the receiver stalls;
// the next item is taken and searched meanwhile and waits for the slot.
// Reset clears the state, the fill count, the tolerance and the output valid
// flag; the memories are not cleared, only filled entries are ever read.

module small_key_value_table
    import skvt_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [TOL_W-1:0]        cfg_wdata,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic [PORT_KEY_W-1:0]   key,
    input  logic [PORT_VALUE_W-1:0] value,

    output logic                    out_valid,
    input  logic                    out_ready,
    output skvt_status_t            status,
    output logic [PORT_VALUE_W-1:0] read_value
);

    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WIDE_W = 64;

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic                    cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0]    key_reg, key_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [TOL_W-1:0]        tol_reg;
    skvt_status_t            res_status_reg, res_status_next;
    logic [PORT_VALUE_W-1:0] res_value_reg, res_value_next;
    logic                    out_valid_reg, out_valid_next;
    skvt_status_t            status_reg, status_next;
    logic [PORT_VALUE_W-1:0] read_value_reg, read_value_next;

    // memories and their ports
    logic [KEY_WIDTH-1:0]    key_mem [ENTRIES];
    logic [VALUE_WIDTH-1:0]  val_mem [ENTRIES];
    logic [KEY_WIDTH-1:0]    key_q_reg;
    logic [VALUE_WIDTH-1:0]  val_q_reg;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    key_we;
    logic                    val_we;
    logic [ADDR_W-1:0]       val_waddr;

    logic [WIDE_W-1:0]       key_wide;
    logic [WIDE_W-1:0]       value_wide;
    logic [WIDE_W-1:0]       val_q_wide;
    logic                    match;
    logic                    issue;
    logic                    hit;
    logic                    table_full;

    // fit the port fields to the stored widths
    assign key_wide   = {{(WIDE_W - PORT_KEY_W){key[PORT_KEY_W-1]}}, key};
    assign value_wide = {{(WIDE_W - PORT_VALUE_W){1'b0}}, value};
    assign val_q_wide = WIDE_W'(val_q_reg);

    // compare the latched key with the entry read last cycle
    skvt_match #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_match (
        .key_a     (key_reg),
        .key_b     (key_q_reg),
        .tolerance (tol_reg),
        .match     (match)
    );

    assign issue      = (idx_reg < fill_reg);
    assign hit        = cmp_valid_reg && match;
    assign table_full = (fill_reg == CNT_W'(ENTRIES));

    // sequencer and result selection
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        fill_next       = fill_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[ADDR_W-1:0];
        key_we          = 1'b0;
        val_we          = 1'b0;
        val_waddr       = fill_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = command;
                    key_next       = key_wide[KEY_WIDTH-1:0];
                    val_next       = value_wide[VALUE_WIDTH-1:0];
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    // first matching entry wins
                    cmp_valid_next = 1'b0;
                    state_next     = S_DONE;
                    if (cmd_reg == CMD_SET)
                    begin
                        val_we          = 1'b1;
                        val_waddr       = cmp_idx_reg;
                        res_status_next = ST_UPDATED;
                        res_value_next  = '0;
                    end
                    else
                    begin
                        res_status_next = ST_FOUND;
                        res_value_next  = val_q_wide[PORT_VALUE_W-1:0];
                    end
                end
                else if (issue)
                begin
                    // read the next filled entry
                    rd_en          = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[ADDR_W-1:0];
                end
                else
                begin
                    // no entry matched
                    cmp_valid_next = 1'b0;
                    state_next     = S_DONE;
                    res_value_next = '0;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    else if (table_full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        key_we          = 1'b1;
                        val_we          = 1'b1;
                        fill_next       = fill_reg + 1'b1;
                        res_status_next = ST_INSERTED;
                    end
                end
            end

            S_DONE:
            begin
                // hand off once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    read_value_next = res_value_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            fill_reg      <= '0;
            tol_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
    end

    // key memory, written on insert
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[fill_reg[ADDR_W-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            key_q_reg <= key_mem[rd_addr];
        end
    end

    // value memory, written on insert or update
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_reg;
        end
        if (rd_en)
        begin
            val_q_reg <= val_mem[rd_addr];
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;

endmodule

@@ hw/rtl/skvt_checker.sv @@
// skvt_checker: port-level checks of the small key-value table
// uses skvt_pkg; bound to small_key_value_table below

module skvt_checker
    import skvt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  skvt_status_t            status,
    input  logic [PORT_VALUE_W-1:0] read_value
);

    // a result carries one of the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_NOT_FOUND))
        else $error("undefined status code on output item");

    // only a found result carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_FOUND)) |-> (read_value == '0))
        else $error("nonzero read_value on an item that is not found");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(read_value)))
        else $error("output item changed while stalled");

endmodule

bind small_key_value_table skvt_checker u_skvt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value)
);
